@@ hdl/rate_drop_jam_detector_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef RATE_DROP_JAM_DETECTOR_UNIT_ASSERT_SVH
`define RATE_DROP_JAM_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RDJ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is held.
`define RDJ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

@@ hdl/rdj_pkg.sv @@
package rdj_pkg;

  // Field widths
  localparam int COUNT_W    = 16;
  localparam int TIME_W     = 32;
  localparam int BASE_W     = 24;
  localparam int RATIO_W    = 8;
  localparam int WEIGHT_W   = 9;
  localparam int STREAK_W   = 8;
  localparam int SUM_W      = 19;
  localparam int SEEN_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;
  localparam logic [BASE_W-1:0]   BASE_MAX   = 24'hFFFFFF;

  // Register reset values
  localparam logic [RATIO_W-1:0]  RST_DROP_RATIO    = 8'd77;
  localparam logic [BASE_W-1:0]   RST_MIN_BASELINE  = 24'd768;
  localparam logic [BASE_W-1:0]   RST_BASE_FLOOR    = 24'd256;
  localparam logic [WEIGHT_W-1:0] RST_EMA_WEIGHT    = 9'd38;
  localparam logic [STREAK_W-1:0] RST_STREAK_LIMIT  = 8'd3;
  localparam logic [TIME_W-1:0]   RST_HOLD_MS       = 32'd8000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_RATIO   = 3'd0,
    REG_MIN_BASELINE = 3'd1,
    REG_BASE_FLOOR   = 3'd2,
    REG_EMA_WEIGHT   = 3'd3,
    REG_STREAK_LIMIT = 3'd4,
    REG_HOLD_MS      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [RATIO_W-1:0]  drop_ratio;
    logic [BASE_W-1:0]   min_baseline;
    logic [BASE_W-1:0]   baseline_floor;
    logic [WEIGHT_W-1:0] ema_weight;
    logic [STREAK_W-1:0] streak_limit;
    logic [TIME_W-1:0]   hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                alert;
    logic                ready_res;
    logic [BASE_W-1:0]   baseline_out;
    logic [STREAK_W-1:0] streak_out;
    logic                low_flag;
  } res_t;

endpackage

@@ hdl/rdj_in_if.sv @@
interface rdj_in_if;
  logic                         valid;
  logic                         ready;
  logic [rdj_pkg::COUNT_W-1:0]  sample_count;
  logic [rdj_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output sample_count, output now_ms, input ready);
  modport sink   (input valid, input sample_count, input now_ms, output ready);
endinterface

@@ hdl/rdj_out_if.sv @@
interface rdj_out_if;
  logic                          valid;
  logic                          ready;
  logic                          alert;
  logic                          ready_res;
  logic [rdj_pkg::BASE_W-1:0]    baseline_out;
  logic [rdj_pkg::STREAK_W-1:0]  streak_out;
  logic                          low_flag;

  modport source (output valid, output alert, output ready_res, output baseline_out,
                  output streak_out, output low_flag, input ready);
  modport sink   (input valid, input alert, input ready_res, input baseline_out,
                  input streak_out, input low_flag, output ready);
endinterface

@@ hdl/rate_drop_jam_detector_unit.sv @@
// Channel   Dir   Payload                                            Handshake
// in_ch     in    sample_count[15:0], now_ms[31:0]                   valid/ready
// out_ch    out   alert, ready_res, baseline_out[23:0],              valid/ready
//                 streak_out[7:0], low_flag
// cfg_*     in    cfg_index[2:0], cfg_wdata[31:0]                    cfg_wr_en
//
// One item per cycle sustained while out_ch does not stall; an item is loaded into
// the input register at acceptance, then its result into the result register.
// The per-item update (multiplies and compares on each path) sits between the
// input register and the result register, so state is current for the next item.
// Reset is synchronous, active low; the block accepts items right after reset.
// A stalled result holds in the output register while one more item waits in
// the input register; in_ch.ready drops only when both are full.
module rate_drop_jam_detector_unit #(
  parameter int WARMUP_ITEMS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rdj_in_if.sink                         in_ch,
  rdj_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [rdj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdj_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rdj_pkg::cfg_t cfg;
  rdj_pkg::res_t res;

  logic                          in_v_r;
  logic [rdj_pkg::COUNT_W-1:0]   in_count_r;
  logic [rdj_pkg::TIME_W-1:0]    in_now_r;
  logic                          out_v_r;
  rdj_pkg::res_t                 out_res_r;
  logic                          advance;
  logic                          in_take;

  // Flow control
  assign advance     = in_v_r & (~out_v_r | out_ch.ready);
  assign in_ch.ready = ~in_v_r | advance;
  assign in_take     = in_ch.valid & in_ch.ready;

  rdj_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  rdj_core #(
    .WARMUP_ITEMS (WARMUP_ITEMS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .sample_count (in_count_r),
    .now_ms       (in_now_r),
    .cfg          (cfg),
    .res          (res)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_count_r <= in_ch.sample_count;
      in_now_r   <= in_ch.now_ms;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.alert        = out_res_r.alert;
  assign out_ch.ready_res    = out_res_r.ready_res;
  assign out_ch.baseline_out = out_res_r.baseline_out;
  assign out_ch.streak_out   = out_res_r.streak_out;
  assign out_ch.low_flag     = out_res_r.low_flag;

endmodule

@@ hdl/rdj_cfg_regs.sv @@
module rdj_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [rdj_pkg::CFG_IDX_W-1:0]     index,
  input  logic [rdj_pkg::CFG_DATA_W-1:0]    wdata,
  output rdj_pkg::cfg_t                     cfg
);

  rdj_pkg::cfg_t cfg_r;
  rdj_pkg::cfg_t cfg_nxt;

  // Index decode; unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (rdj_pkg::cfg_reg_t'(index))
        rdj_pkg::REG_DROP_RATIO:   cfg_nxt.drop_ratio     = wdata[rdj_pkg::RATIO_W-1:0];
        rdj_pkg::REG_MIN_BASELINE: cfg_nxt.min_baseline   = wdata[rdj_pkg::BASE_W-1:0];
        rdj_pkg::REG_BASE_FLOOR:   cfg_nxt.baseline_floor = wdata[rdj_pkg::BASE_W-1:0];
        rdj_pkg::REG_EMA_WEIGHT:   cfg_nxt.ema_weight     = wdata[rdj_pkg::WEIGHT_W-1:0];
        rdj_pkg::REG_STREAK_LIMIT: cfg_nxt.streak_limit   = wdata[rdj_pkg::STREAK_W-1:0];
        rdj_pkg::REG_HOLD_MS:      cfg_nxt.hold_ms        = wdata[rdj_pkg::TIME_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_ratio     <= rdj_pkg::RST_DROP_RATIO;
      cfg_r.min_baseline   <= rdj_pkg::RST_MIN_BASELINE;
      cfg_r.baseline_floor <= rdj_pkg::RST_BASE_FLOOR;
      cfg_r.ema_weight     <= rdj_pkg::RST_EMA_WEIGHT;
      cfg_r.streak_limit   <= rdj_pkg::RST_STREAK_LIMIT;
      cfg_r.hold_ms        <= rdj_pkg::RST_HOLD_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/rdj_core.sv @@
module rdj_core #(
  parameter int WARMUP_ITEMS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [rdj_pkg::COUNT_W-1:0]     sample_count,
  input  logic [rdj_pkg::TIME_W-1:0]      now_ms,
  input  rdj_pkg::cfg_t                   cfg,
  output rdj_pkg::res_t                   res
);

  // Mean = (sum << 8) / WARMUP_ITEMS via reciprocal: exact for sums below 2^19
  localparam int RECIP_SH = 30;
  localparam int RECIP_W  = 31;
  localparam int PROD_W   = rdj_pkg::SUM_W + RECIP_W;
  localparam int QUOT_W   = PROD_W - (RECIP_SH - 8);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SH) + WARMUP_ITEMS - 1) / WARMUP_ITEMS);
  localparam logic [rdj_pkg::SEEN_W-1:0] WARM_LAST = rdj_pkg::SEEN_W'(WARMUP_ITEMS);

  localparam int EMA_W = rdj_pkg::BASE_W + rdj_pkg::WEIGHT_W + 1;

  // State
  logic [rdj_pkg::SUM_W-1:0]    warm_sum_r,  warm_sum_nxt;
  logic [rdj_pkg::SEEN_W-1:0]   warm_seen_r, warm_seen_nxt;
  logic                         have_r,      have_nxt;
  logic [rdj_pkg::BASE_W-1:0]   base_r,      base_nxt;
  logic [rdj_pkg::STREAK_W-1:0] run_r,       run_nxt;
  logic                         alert_r,     alert_nxt;
  logic [rdj_pkg::TIME_W-1:0]   stamp_r,     stamp_nxt;

  // Warm-up path
  logic [PROD_W-1:0]          warm_prod;
  logic [QUOT_W-1:0]          warm_q;
  logic [rdj_pkg::BASE_W-1:0] warm_base;
  logic                       warm_done;

  // Tracking path
  logic [31:0]                  lhs, rhs;
  logic                         low;
  logic [rdj_pkg::WEIGHT_W-1:0] w_sat, w_inv;
  logic [EMA_W-1:0]             ema_old, ema_new, ema_sum;
  logic [EMA_W-9:0]             ema_q;
  logic [rdj_pkg::BASE_W-1:0]   ema_base;
  logic [rdj_pkg::STREAK_W-1:0] run_inc, run_trk;
  logic                         trig, expired;
  logic [rdj_pkg::TIME_W-1:0]   elapsed;

  // Warm-up accumulate and mean
  always_comb begin
    warm_sum_nxt  = warm_sum_r + rdj_pkg::SUM_W'(sample_count);
    warm_seen_nxt = warm_seen_r + 1'b1;
    warm_done     = (warm_seen_nxt == WARM_LAST);
    warm_prod     = PROD_W'(warm_sum_nxt) * PROD_W'(RECIP);
    warm_q        = warm_prod[PROD_W-1:RECIP_SH-8];
    if (warm_q < QUOT_W'(cfg.baseline_floor)) begin
      warm_base = cfg.baseline_floor;
    end else if (warm_q > QUOT_W'(rdj_pkg::BASE_MAX)) begin
      warm_base = rdj_pkg::BASE_MAX;
    end else begin
      warm_base = warm_q[rdj_pkg::BASE_W-1:0];
    end
  end

  // Low test: count * 2^16 against ratio * baseline, only above min_baseline
  always_comb begin
    lhs = {sample_count, 16'b0};
    rhs = 32'(cfg.drop_ratio) * 32'(base_r);
    low = (lhs < rhs) && (base_r > cfg.min_baseline);
  end

  // Exponential average, weight saturated at one
  always_comb begin
    w_sat    = (cfg.ema_weight > rdj_pkg::WEIGHT_ONE) ? rdj_pkg::WEIGHT_ONE : cfg.ema_weight;
    w_inv    = rdj_pkg::WEIGHT_ONE - w_sat;
    ema_old  = EMA_W'(base_r) * EMA_W'(w_inv);
    ema_new  = EMA_W'({sample_count, 8'b0}) * EMA_W'(w_sat);
    ema_sum  = ema_old + ema_new;
    ema_q    = ema_sum[EMA_W-1:8];
    ema_base = (ema_q > (EMA_W-8)'(rdj_pkg::BASE_MAX)) ? rdj_pkg::BASE_MAX
                                                       : ema_q[rdj_pkg::BASE_W-1:0];
  end

  // Streak, alert set and hold expiry (elapsed is measured from the last trigger's stamp)
  always_comb begin
    run_inc = (run_r == rdj_pkg::STREAK_MAX) ? run_r : run_r + 1'b1;
    run_trk = low ? run_inc : '0;
    trig    = (run_trk >= cfg.streak_limit);
    elapsed = now_ms - stamp_r;
    expired = (elapsed > cfg.hold_ms);
  end

  // Next-state select
  always_comb begin
    have_nxt      = have_r;
    base_nxt      = base_r;
    run_nxt       = run_r;
    alert_nxt     = alert_r;
    stamp_nxt     = stamp_r;
    if (!have_r) begin
      if (warm_done) begin
        have_nxt = 1'b1;
        base_nxt = warm_base;
      end
    end else begin
      run_nxt   = run_trk;
      base_nxt  = low ? base_r : ema_base;
      alert_nxt = trig | (alert_r & ~expired);
      stamp_nxt = trig ? now_ms : stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_sum_r  <= '0;
      warm_seen_r <= '0;
      have_r      <= 1'b0;
      base_r      <= '0;
      run_r       <= '0;
      alert_r     <= 1'b0;
      stamp_r     <= '0;
    end else if (step) begin
      if (!have_r) begin
        warm_sum_r  <= warm_sum_nxt;
        warm_seen_r <= warm_seen_nxt;
      end
      have_r  <= have_nxt;
      base_r  <= base_nxt;
      run_r   <= run_nxt;
      alert_r <= alert_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  // Result reflects the state after this item
  always_comb begin
    res.alert        = alert_nxt;
    res.ready_res    = have_nxt;
    res.baseline_out = base_nxt;
    res.streak_out   = run_nxt;
    res.low_flag     = have_r & low;
  end

endmodule

@@ hdl/rdj_checker.sv @@
`include "rate_drop_jam_detector_unit_assert.svh"

module rdj_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_alert,
  input logic                          out_ready_res,
  input logic [rdj_pkg::BASE_W-1:0]    out_baseline,
  input logic [rdj_pkg::STREAK_W-1:0]  out_streak,
  input logic                          out_low
);

  logic seen_ready_r;

  // Remember that warm-up has finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ready_r <= 1'b0;
    end else if (out_valid && out_ready && out_ready_res) begin
      seen_ready_r <= 1'b1;
    end
  end

  `RDJ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_baseline) && $stable(out_streak) && $stable(out_alert))
  `RDJ_ASSERT_IMP(a_in_open, clk, rst_n, !out_valid, in_ready)
  `RDJ_ASSERT_IMP(a_ready_sticky, clk, rst_n, out_valid && seen_ready_r, out_ready_res)
  `RDJ_ASSERT_IMP(a_warm_quiet, clk, rst_n, out_valid && !out_ready_res, !out_alert && !out_low && out_streak == 0 && out_baseline == 0)
  `RDJ_ASSERT_IMP(a_low_streak, clk, rst_n, out_valid && out_low, out_ready_res && out_streak != 0)

endmodule

bind rate_drop_jam_detector_unit rdj_checker u_rdj_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_alert     (out_ch.alert),
  .out_ready_res (out_ch.ready_res),
  .out_baseline  (out_ch.baseline_out),
  .out_streak    (out_ch.streak_out),
  .out_low       (out_ch.low_flag)
);
